// ===== design/i2p_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared constants, types and character helpers for the infix to postfix
// converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  localparam logic [1:0] CLS_ALNUM = 2'd0;
  localparam logic [1:0] CLS_OPEN  = 2'd1;
  localparam logic [1:0] CLS_CLOSE = 2'd2;
  localparam logic [1:0] CLS_OPER  = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNM_CLOSE = 2'd2;
  localparam logic [1:0] ERR_UNM_OPEN  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // take a new item
    logic       push;      // push the current character
    logic       pop;       // drop the stack top
    logic       emit;      // release a character into the pending slot
    logic       emit_top;  // source of the released character: 1 top, 0 current
    logic       err_set;   // record an error if none is recorded yet
    logic [1:0] err_code;
    logic       finish;    // send the closing beat of the item
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cls;
    logic       empty;
    logic       full;
    logic       top_open;
    logic       outranks;
    logic       last;
    logic       pend_valid;
    logic       slot_free;
  } stat_t;

  function automatic logic [1:0] rank_of(input logic [7:0] ch);
    logic [1:0] r;
    r = 2'd0;
    if (ch == CH_POW) r = 2'd3;
    else if (ch == CH_MUL || ch == CH_DIV) r = 2'd2;
    else if (ch == CH_ADD || ch == CH_SUB) r = 2'd1;
    return r;
  endfunction

  function automatic logic [1:0] char_class(input logic [7:0] ch);
    logic [1:0] c;
    if ((ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
        (ch >= 8'h61 && ch <= 8'h7A)) c = CLS_ALNUM;
    else if (ch == CH_OPEN) c = CLS_OPEN;
    else if (ch == CH_CLOSE) c = CLS_CLOSE;
    else c = CLS_OPER;
    return c;
  endfunction

endpackage

// ===== design/i2p_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_in_if
// Input channel: one infix character per beat.
// ----------------------------------------------------------------------------
interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_expr;

  modport source (output valid, output in_char, output end_of_expr, input ready);
  modport sink   (input valid, input in_char, input end_of_expr, output ready);
endinterface

// ===== design/i2p_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_out_if
// Output channel: one postfix character or status per beat.
// ----------------------------------------------------------------------------
interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       run_last;
  logic       expr_done;
  logic [1:0] error_code;

  modport source (output valid, output out_char, output has_char, output run_last,
                  output expr_done, output error_code, input ready);
  modport sink   (input valid, input out_char, input has_char, input run_last,
                  input expr_done, input error_code, output ready);
endinterface

// ===== design/i2p_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_datapath
// Operator stack, current item, one-deep pending character and output register.
// ----------------------------------------------------------------------------
module i2p_datapath (
  input  logic            clk,
  input  logic            rst,
  input  i2p_pkg::cmd_t   cmd,
  output i2p_pkg::stat_t  stat,
  input  logic [7:0]      in_char,
  input  logic            end_of_expr,
  i2p_out_if.source       out_ch
);

  logic [7:0]               stack [i2p_pkg::STACK_DEPTH];
  logic [i2p_pkg::CNT_W-1:0] count;
  logic [i2p_pkg::CNT_W-1:0] top_addr;
  logic [7:0]               top;
  logic [7:0]               cur_char;
  logic                     cur_last;
  logic [1:0]               err;
  logic                     pend_valid;
  logic [7:0]               pend_char;
  logic                     out_valid;
  logic [7:0]               out_char;
  logic                     out_has;
  logic                     out_run_last;
  logic                     out_done;
  logic [1:0]               out_err;
  logic                     send;
  logic [1:0]               rank_top;
  logic [1:0]               rank_cur;

  assign top_addr = count - i2p_pkg::CNT_W'(1);
  assign top      = stack[top_addr[i2p_pkg::IDX_W-1:0]];
  assign rank_top = i2p_pkg::rank_of(top);
  assign rank_cur = i2p_pkg::rank_of(cur_char);
  // A character already held is sent on when a new one arrives or the item closes.
  assign send     = (cmd.emit && pend_valid) || cmd.finish;

  always_comb begin
    stat.cls        = i2p_pkg::char_class(cur_char);
    stat.empty      = (count == '0);
    stat.full       = (count == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH));
    stat.top_open   = (top == i2p_pkg::CH_OPEN);
    stat.outranks   = (rank_top > rank_cur) ||
                      ((rank_top == rank_cur) && (cur_char != i2p_pkg::CH_POW));
    stat.last       = cur_last;
    stat.pend_valid = pend_valid;
    stat.slot_free  = !out_valid || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack[count[i2p_pkg::IDX_W-1:0]] <= cur_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.push) count <= count + i2p_pkg::CNT_W'(1);
      else if (cmd.pop) count <= top_addr;
      if (cmd.emit) pend_valid <= 1'b1;
      else if (cmd.finish || cmd.load) pend_valid <= 1'b0;
      if (send) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_char <= in_char;
      cur_last <= end_of_expr;
      err      <= i2p_pkg::ERR_NONE;
    end else if (cmd.err_set && err == i2p_pkg::ERR_NONE) begin
      err <= cmd.err_code;
    end
    if (cmd.emit) begin
      pend_char <= cmd.emit_top ? top : cur_char;
    end
    if (cmd.finish) begin
      out_char     <= pend_valid ? pend_char : 8'h00;
      out_has      <= pend_valid;
      out_run_last <= 1'b1;
      out_done     <= cur_last;
      out_err      <= err;
    end else if (send) begin
      out_char     <= pend_char;
      out_has      <= 1'b1;
      out_run_last <= 1'b0;
      out_done     <= 1'b0;
      out_err      <= i2p_pkg::ERR_NONE;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.out_char   = out_char;
  assign out_ch.has_char   = out_has;
  assign out_ch.run_last   = out_run_last;
  assign out_ch.expr_done  = out_done;
  assign out_ch.error_code = out_err;

endmodule

// ===== design/i2p_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer: classifies each character; pops one a cycle while not stalled.
// ----------------------------------------------------------------------------
module i2p_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  i2p_pkg::stat_t stat,
  output i2p_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_CLOSE    = 3'd2;
  localparam logic [2:0] S_OPPOP    = 3'd3;
  localparam logic [2:0] S_DRAIN    = 3'd4;
  localparam logic [2:0] S_FINAL    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       can_emit;

  // Releasing a character only needs the output register when one is pending.
  assign can_emit = !stat.pend_valid || stat.slot_free;
  // Nothing is taken while reset is held.
  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.cls)
          i2p_pkg::CLS_ALNUM: begin
            if (can_emit) begin
              cmd.emit   = 1'b1;
              state_next = S_DRAIN;
            end
          end
          i2p_pkg::CLS_OPEN: begin
            if (stat.full) begin
              cmd.err_set  = 1'b1;
              cmd.err_code = i2p_pkg::ERR_OVERFLOW;
            end else begin
              cmd.push = 1'b1;
            end
            state_next = S_DRAIN;
          end
          i2p_pkg::CLS_CLOSE: state_next = S_CLOSE;
          default:            state_next = S_OPPOP;
        endcase
      end
      S_CLOSE: begin
        if (stat.empty) begin
          cmd.err_set  = 1'b1;
          cmd.err_code = i2p_pkg::ERR_UNM_CLOSE;
          state_next   = S_DRAIN;
        end else if (stat.top_open) begin
          cmd.pop    = 1'b1;
          state_next = S_DRAIN;
        end else if (can_emit) begin
          cmd.emit     = 1'b1;
          cmd.emit_top = 1'b1;
          cmd.pop      = 1'b1;
        end
      end
      S_OPPOP: begin
        if (!stat.empty && !stat.top_open && stat.outranks) begin
          if (can_emit) begin
            cmd.emit     = 1'b1;
            cmd.emit_top = 1'b1;
            cmd.pop      = 1'b1;
          end
        end else begin
          if (stat.full) begin
            cmd.err_set  = 1'b1;
            cmd.err_code = i2p_pkg::ERR_OVERFLOW;
          end else begin
            cmd.push = 1'b1;
          end
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.last || stat.empty) begin
          state_next = S_FINAL;
        end else if (stat.top_open) begin
          cmd.pop      = 1'b1;
          cmd.err_set  = 1'b1;
          cmd.err_code = i2p_pkg::ERR_UNM_OPEN;
        end else if (can_emit) begin
          cmd.emit     = 1'b1;
          cmd.emit_top = 1'b1;
          cmd.pop      = 1'b1;
        end
      end
      S_FINAL: begin
        if (stat.slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix character stream into postfix beats.
// ----------------------------------------------------------------------------
// Throughput: one item at a time; a new character is taken only once the
// closing beat of the previous one has been loaded into the output register.
// Latency: each earlier beat is presented at the edge that releases the next
// character; the closing beat is presented as input readiness returns.
// Output back-pressure stalls any release or closing beat that needs the register.
// Reset (rst, synchronous, active high) empties the stack and the output register.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
  input  logic      clk,
  input  logic      rst,
  i2p_in_if.sink    in_ch,
  i2p_out_if.source out_ch
);

  // The controller and the datapath talk only through these two bundles.
  i2p_pkg::cmd_t  cmd;
  i2p_pkg::stat_t stat;

  // The controller decides, cycle by cycle, whether to push, pop or release a
  // character. It stays in each popping state until the stop condition of
  // that loop is met, and it waits whenever a release would need the output
  // register while a beat there has not yet been taken.
  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds one released character back, so that the final beat
  // of an item can carry the run_last, expr_done and error_code fields. When
  // an item releases nothing, its final beat is a status-only one.
  i2p_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_char     (in_ch.in_char),
    .end_of_expr (in_ch.end_of_expr),
    .out_ch      (out_ch)
  );

endmodule

// ===== design/i2p_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module i2p_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       has_char,
  input logic       run_last,
  input logic       expr_done,
  input logic [1:0] error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char))
    else $error("output beat changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_char |-> run_last && (out_char == 8'h00))
    else $error("status-only beat is not the closing beat");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (expr_done || (error_code != i2p_pkg::ERR_NONE)) |-> run_last)
    else $error("completion or error flagged before the closing beat");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_char   (out_ch.out_char),
  .has_char   (out_ch.has_char),
  .run_last   (out_ch.run_last),
  .expr_done  (out_ch.expr_done),
  .error_code (out_ch.error_code)
);

// ===== tb/sv/infix_to_postfix_converter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb
// Self-checking bench for the shunting-yard converter. A directed stimulus
// list is followed by random expressions, deep nests and noise. Every
// accepted character goes through a shadow operator stack, and every output
// beat is checked against the oldest predicted beat.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;
  import i2p_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 390;
  localparam int MAX_REPORTS = 10;

  // One output beat, laid out as the output channel carries it.
  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       run_last;
    logic       expr_done;
    logic [1:0] error_code;
  } postfix_beat_t;

  // One input character. Where typed is set, the beat field holds the only
  // beat that the character may produce, written out by hand.
  typedef struct packed {
    logic [7:0]    ch;
    logic          eoe;
    logic          typed;
    postfix_beat_t beat;
  } char_item_t;

  typedef struct packed {
    logic [7:0]    ch;
    logic          eoe;
    logic [5:0]    reps;
    logic          typed;
    postfix_beat_t beat;
  } directed_row_t;

  localparam postfix_beat_t NO_BEAT = '0;

  localparam logic [7:0] ARITH_OPS [5] = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_POW};

  // The directed list. Rows with a hand-written beat are those whose answer is
  // plain: a fresh block, status-only beats, the extreme bytes and the error
  // codes. The others are left to the shadow stack.
  localparam int N_ROWS = 29;
  localparam directed_row_t DIRECTED_ROWS [N_ROWS] = '{
    // A lone operand straight after reset comes out unchanged.
    '{"a",      1'b0, 6'd1,  1'b1, '{"a",   1'b1, 1'b1, 1'b0, ERR_NONE}},
    // A closing bracket on an empty stack.
    '{CH_CLOSE, 1'b0, 6'd1,  1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, ERR_UNM_CLOSE}},
    // Fill the stack to the brim with opening brackets.
    '{CH_OPEN,  1'b0, 6'd32, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE}},
    // One more overflows; the drain then meets 32 unmatched brackets, but the
    // overflow came first and is the one reported.
    '{CH_OPEN,  1'b1, 6'd1,  1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ERR_OVERFLOW}},
    // The extreme bytes are rank-zero operators: pushed, then drained at once.
    '{8'h00,    1'b1, 6'd1,  1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, ERR_NONE}},
    '{8'hFF,    1'b1, 6'd1,  1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1, ERR_NONE}},
    '{CH_OPEN,  1'b0, 6'd1,  1'b0, NO_BEAT},
    '{"0",      1'b0, 6'd1,  1'b1, '{"0",   1'b1, 1'b1, 1'b0, ERR_NONE}},
    '{CH_ADD,   1'b0, 6'd1,  1'b0, NO_BEAT},
    '{"9",      1'b0, 6'd1,  1'b0, NO_BEAT},
    '{CH_CLOSE, 1'b0, 6'd1,  1'b0, NO_BEAT},
    '{CH_MUL,   1'b0, 6'd1,  1'b0, NO_BEAT},
    '{"A",      1'b0, 6'd1,  1'b0, NO_BEAT},
    '{CH_POW,   1'b0, 6'd1,  1'b0, NO_BEAT},
    '{"Z",      1'b0, 6'd1,  1'b0, NO_BEAT},
    // A second power operator must not pop the first one.
    '{CH_POW,   1'b0, 6'd1,  1'b0, NO_BEAT},
    '{"z",      1'b0, 6'd1,  1'b0, NO_BEAT},
    '{CH_SUB,   1'b0, 6'd1,  1'b0, NO_BEAT},
    '{8'h80,    1'b0, 6'd1,  1'b0, NO_BEAT},
    // Bytes just outside the digit and letter ranges are operators too.
    '{":",      1'b0, 6'd1,  1'b0, NO_BEAT},
    '{CH_DIV,   1'b0, 6'd1,  1'b0, NO_BEAT},
    '{CH_OPEN,  1'b0, 6'd1,  1'b0, NO_BEAT},
    '{"@",      1'b0, 6'd1,  1'b0, NO_BEAT},
    '{8'h60,    1'b0, 6'd1,  1'b0, NO_BEAT},
    '{CH_CLOSE, 1'b1, 6'd1,  1'b0, NO_BEAT},
    // An opening bracket left open when the expression ends.
    '{CH_OPEN,  1'b0, 6'd1,  1'b0, NO_BEAT},
    '{"b",      1'b1, 6'd1,  1'b1, '{"b",   1'b1, 1'b1, 1'b1, ERR_UNM_OPEN}},
    // A closing bracket that empties the stack without finding its partner.
    '{CH_ADD,   1'b0, 6'd1,  1'b0, NO_BEAT},
    '{CH_CLOSE, 1'b1, 6'd1,  1'b1, '{CH_ADD, 1'b1, 1'b1, 1'b1, ERR_UNM_CLOSE}}
  };

  // Idling per phase, in percent: none, sender only, receiver only, both.
  localparam int TX_IDLE  [4] = '{0, 78, 0, 18};
  localparam int RX_STALL [4] = '{0, 0, 78, 18};

  logic clk = 1'b0;
  logic rst;

  i2p_in_if  in_ch ();
  i2p_out_if out_ch ();

  infix_to_postfix_converter dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  char_item_t    stim_q [$];
  postfix_beat_t postfix_q [$];

  // Shadow copy of the operator stack.
  logic [7:0] shadow_stack [STACK_DEPTH];
  int         shadow_depth = 0;

  int fault_count = 0;
  int cycle_count = 0;
  int acc_idx     = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_arm = 1'b0;
  logic rx_hold;

  char_item_t    acc_item;
  postfix_beat_t want_beat;
  postfix_beat_t seen_beat;

  function automatic void note_fault(input string what);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, what);
    end
  endfunction

  function automatic logic [1:0] op_prec(input logic [7:0] ch);
    case (ch)
      CH_POW:         return 2'd3;
      CH_MUL, CH_DIV: return 2'd2;
      CH_ADD, CH_SUB: return 2'd1;
      default:        return 2'd0;
    endcase
  endfunction

  // Only ASCII digits and letters count as operands.
  function automatic logic is_operand(input logic [7:0] ch);
    return (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "Z") ||
           (ch >= "a" && ch <= "z");
  endfunction

  // Runs one character through the shadow stack. When record is set, the
  // beats that it releases are queued as expectations; otherwise only the
  // stack moves on.
  function automatic void shunt_char(input logic [7:0] ch, input logic eoe,
                                     input logic record);
    logic [7:0]    released [$];
    logic [1:0]    err;
    logic [7:0]    top;
    logic          matched;
    postfix_beat_t b;
    int            n;

    err = ERR_NONE;
    if (is_operand(ch)) begin
      released.push_back(ch);
    end else if (ch == CH_OPEN) begin
      if (shadow_depth < STACK_DEPTH) begin
        shadow_stack[shadow_depth] = ch;
        shadow_depth++;
      end else begin
        err = ERR_OVERFLOW;
      end
    end else if (ch == CH_CLOSE) begin
      matched = 1'b0;
      while (shadow_depth > 0 && !matched) begin
        shadow_depth--;
        top = shadow_stack[shadow_depth];
        if (top == CH_OPEN) matched = 1'b1;
        else released.push_back(top);
      end
      if (!matched) err = ERR_UNM_CLOSE;
    end else begin
      // Pop while the top outranks the newcomer, or ties with it and the
      // newcomer is left-associative; an opening bracket stops the pops.
      while (shadow_depth > 0) begin
        top = shadow_stack[shadow_depth - 1];
        if (top == CH_OPEN) break;
        if (op_prec(top) > op_prec(ch) ||
            (op_prec(top) == op_prec(ch) && ch != CH_POW)) begin
          released.push_back(top);
          shadow_depth--;
        end else begin
          break;
        end
      end
      if (shadow_depth < STACK_DEPTH) begin
        shadow_stack[shadow_depth] = ch;
        shadow_depth++;
      end else begin
        err = ERR_OVERFLOW;
      end
    end

    if (eoe) begin
      while (shadow_depth > 0) begin
        shadow_depth--;
        top = shadow_stack[shadow_depth];
        if (top != CH_OPEN) released.push_back(top);
        else if (err == ERR_NONE) err = ERR_UNM_OPEN;
      end
    end

    if (record) begin
      n = (released.size() == 0) ? 1 : released.size();
      for (int k = 0; k < n; k++) begin
        b = '0;
        if (k < released.size()) begin
          b.out_char = released[k];
          b.has_char = 1'b1;
        end
        if (k == n - 1) begin
          b.run_last   = 1'b1;
          b.expr_done  = eoe;
          b.error_code = err;
        end
        postfix_q.push_back(b);
      end
    end
  endfunction

  function automatic void add_char(input logic [7:0] ch, input logic eoe);
    char_item_t it;
    it       = '0;
    it.ch    = ch;
    it.eoe   = eoe;
    stim_q.push_back(it);
  endfunction

  function automatic logic [7:0] rand_operand();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  // Mostly the five arithmetic operators; now and then any byte at all.
  function automatic logic [7:0] rand_operator();
    if ($urandom_range(0, 99) < 90) return ARITH_OPS[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Appends one expression with random nesting, ending in the last character.
  // lead_opens opening brackets come first; pow_only builds a power chain.
  function automatic void add_expression(input int lead_opens, input int n_opnd,
                                         input logic pow_only);
    logic [7:0] text [$];
    int         depth;

    depth = lead_opens;
    repeat (lead_opens) text.push_back(CH_OPEN);
    for (int k = 0; k < n_opnd; k++) begin
      while (depth < 12 && $urandom_range(0, 99) < 20) begin
        text.push_back(CH_OPEN);
        depth++;
      end
      text.push_back(rand_operand());
      while (depth > 0 && $urandom_range(0, 99) < 35) begin
        text.push_back(CH_CLOSE);
        depth--;
      end
      if (k < n_opnd - 1) text.push_back(pow_only ? CH_POW : rand_operator());
    end
    // Now and then the brackets are left open on purpose.
    if ($urandom_range(0, 99) < 90) begin
      repeat (depth) text.push_back(CH_CLOSE);
    end
    for (int k = 0; k < text.size(); k++) begin
      add_char(text[k], k == text.size() - 1);
    end
  endfunction

  // Receiver: ready is redrawn at every falling edge. During the hold-off it
  // stays low so that the block backs up and stalls its input.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // The hold-off runs in its own process and counts its own cycles, while
  // the sender keeps offering characters at full rate.
  initial begin
    rx_hold = 1'b0;
    wait (hold_arm);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Both channels are watched at the rising edge. An accepted character is
  // predicted before any beat of the same edge is checked, although in
  // practice its first beat only comes out later.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        acc_item = stim_q[acc_idx];
        acc_idx++;
        shunt_char(acc_item.ch, acc_item.eoe, !acc_item.typed);
        if (acc_item.typed) postfix_q.push_back(acc_item.beat);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_beat = '{out_ch.out_char, out_ch.has_char, out_ch.run_last,
                      out_ch.expr_done, out_ch.error_code};
        if (postfix_q.size() == 0) begin
          note_fault($sformatf("unexpected beat: char %h has %b last %b done %b err %0d",
                               seen_beat.out_char, seen_beat.has_char,
                               seen_beat.run_last, seen_beat.expr_done,
                               seen_beat.error_code));
        end else begin
          want_beat = postfix_q.pop_front();
          if (seen_beat != want_beat) begin
            note_fault($sformatf({"beat mismatch: expected char %h has %b last %b ",
                                  "done %b err %0d, got char %h has %b last %b ",
                                  "done %b err %0d"},
                                 want_beat.out_char, want_beat.has_char,
                                 want_beat.run_last, want_beat.expr_done,
                                 want_beat.error_code, seen_beat.out_char,
                                 seen_beat.has_char, seen_beat.run_last,
                                 seen_beat.expr_done, seen_beat.error_code));
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    char_item_t it;
    int         n_dir;
    int         quarter;
    int         ph;
    int         r;
    int         drained;

    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.in_char     = 8'h00;
    in_ch.end_of_expr = 1'b0;

    // Expand the directed rows into the stimulus list.
    for (int row = 0; row < N_ROWS; row++) begin
      for (int k = 0; k < DIRECTED_ROWS[row].reps; k++) begin
        it.ch    = DIRECTED_ROWS[row].ch;
        it.eoe   = DIRECTED_ROWS[row].eoe;
        it.typed = DIRECTED_ROWS[row].typed;
        it.beat  = DIRECTED_ROWS[row].beat;
        stim_q.push_back(it);
      end
    end
    n_dir = stim_q.size();

    // Random part: mostly well-formed expressions, with some deep nests that
    // run into the stack limit, long power chains that pile up on the stack,
    // and bursts of arbitrary bytes with the odd end flag.
    while (stim_q.size() - n_dir < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        add_expression(0, $urandom_range(1, 8), 1'b0);
      end else if (r < 78) begin
        add_expression($urandom_range(26, 36), $urandom_range(1, 3), 1'b0);
      end else if (r < 83) begin
        add_expression(0, $urandom_range(28, 36), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          add_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end
    end
    quarter = (stim_q.size() - n_dir + 3) / 4;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sender: each beat is offered at a falling edge and held until it is
    // taken at a rising edge. Valid is only lowered for a gap, so it never
    // drops and rises within one step.
    for (int i = 0; i < stim_q.size(); i++) begin
      if (i >= n_dir) begin
        ph           = (i - n_dir) / quarter;
        tx_idle_pct  = TX_IDLE[ph];
        rx_stall_pct = RX_STALL[ph];
      end
      if (i == n_dir) hold_arm = 1'b1;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
      in_ch.valid       <= 1'b1;
      in_ch.in_char     <= stim_q[i].ch;
      in_ch.end_of_expr <= stim_q[i].eoe;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;

    // Let the outstanding beats come out, then run on for the TAIL_CYCLES tail
    // in case anything unexpected follows.
    drained = 0;
    while (postfix_q.size() != 0 && drained < DRAIN_LIMIT) begin
      @(posedge clk);
      drained++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (postfix_q.size() != 0) begin
      note_fault($sformatf("%0d expected beats never arrived", postfix_q.size()));
    end

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
